// ----- rtl/csm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Clock set mode controller package
// Shared types and codes for the alarm-clock setting controller.
// ----------------------------------------------------------------------------
package csm_pkg;

    typedef enum logic [2:0] {
        MODE_HOME     = 3'd0,
        MODE_ENABLE   = 3'd1,
        MODE_SET_ALM  = 3'd2,
        MODE_SET_TIME = 3'd3,
        MODE_RINGING  = 3'd4
    } mode_t;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_MODE = 3'd1;
    localparam logic [2:0] OP_SET  = 3'd2;
    localparam logic [2:0] OP_INC  = 3'd3;
    localparam logic [2:0] OP_DEC  = 3'd4;

    localparam logic [1:0] STEP_SELECT = 2'd0;
    localparam logic [1:0] STEP_HOURS  = 2'd1;
    localparam logic [1:0] STEP_TENS   = 2'd2;
    localparam logic [1:0] STEP_UNITS  = 2'd3;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_CLOCK  = 2'd1;
    localparam logic [1:0] CMD_ALARM  = 2'd2;
    localparam logic [1:0] CMD_ENABLE = 2'd3;

    localparam logic [3:0] COL_NONE   = 4'd0;
    localparam logic [3:0] COL_ENABLE = 4'd4;
    localparam logic [3:0] COL_HOURS  = 4'd5;
    localparam logic [3:0] COL_TENS   = 4'd7;
    localparam logic [3:0] COL_UNITS  = 4'd8;

    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'h7500;

    typedef struct packed {
        logic [2:0]  op;
        logic        press_seen;
        logic        ringing;
        logic        alarm_on;
        logic [15:0] now_ms;
        logic [4:0]  clock_hours;
        logic [5:0]  clock_minutes;
        logic [4:0]  stored_alarm_hours;
        logic [5:0]  stored_alarm_minutes;
    } csm_in_t;

    typedef struct packed {
        logic [2:0] mode_now;
        logic [1:0] step_now;
        logic [4:0] shown_hours;
        logic [5:0] shown_minutes;
        logic [4:0] shown_alarm_hours;
        logic [5:0] shown_alarm_minutes;
        logic [1:0] command;
        logic       enable_value;
        logic       changed;
        logic       cursor_on;
        logic       cursor_row;
        logic [3:0] cursor_col;
    } csm_out_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  step;
        logic [4:0]  day_hours;
        logic [5:0]  day_minutes;
        logic [4:0]  alm_hours;
        logic [5:0]  alm_minutes;
        logic [15:0] last_press;
    } csm_state_t;

endpackage
`default_nettype wire

// ----- rtl/csm_next.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Clock set mode next-state logic
// Computes the next kept state and the result for one request.
// ----------------------------------------------------------------------------
module csm_next (
    input  var csm_pkg::csm_state_t cur,
    input  var csm_pkg::csm_in_t    req,
    input  wire logic [15:0]        idle_timeout,
    output csm_pkg::csm_state_t     nxt,
    output csm_pkg::csm_out_t       res
);

    function automatic logic [4:0] wrap_hours(input logic up, input logic [4:0] v);
        if (up)
            return (v == 5'd23) ? 5'd0 : v + 5'd1;
        return (v == 5'd0) ? 5'd23 : v - 5'd1;
    endfunction

    function automatic logic [2:0] wrap_tens(input logic up, input logic [2:0] v);
        if (up)
            return (v >= 3'd5) ? 3'd0 : v + 3'd1;
        return (v == 3'd0) ? 3'd5 : v - 3'd1;
    endfunction

    function automatic logic [3:0] wrap_units(input logic up, input logic [3:0] v);
        if (up)
            return (v >= 4'd9) ? 4'd0 : v + 4'd1;
        return (v == 4'd0) ? 4'd9 : v - 4'd1;
    endfunction

    function automatic logic [5:0] times_ten(input logic [2:0] t);
        return {t, 3'b000} + {2'b00, t, 1'b0};
    endfunction

    csm_pkg::mode_t mode;
    logic [1:0]  step;
    logic [4:0]  dh;
    logic [5:0]  dm;
    logic [4:0]  ah;
    logic [5:0]  am;
    logic [4:0]  clk_h;
    logic [5:0]  clk_m;
    logic [4:0]  sa_h;
    logic [5:0]  sa_m;
    logic [1:0]  cmd;
    logic        en;
    logic [15:0] last_press;
    logic [15:0] elapsed;
    logic        up;
    logic        edit_time;
    logic [4:0]  eh;
    logic [5:0]  em;
    logic [9:0]  prod;
    logic [2:0]  tens;
    logic [5:0]  unit_diff;
    logic [3:0]  units;
    logic [4:0]  dh_r;
    logic [5:0]  dm_r;
    logic [4:0]  ah_r;
    logic [5:0]  am_r;
    logic        c_on;
    logic        c_row;
    logic [3:0]  c_col;

    always_comb
    begin
        mode       = cur.mode;
        step       = cur.step;
        dh         = cur.day_hours;
        dm         = cur.day_minutes;
        ah         = cur.alm_hours;
        am         = cur.alm_minutes;
        clk_h      = req.clock_hours;
        clk_m      = req.clock_minutes;
        sa_h       = req.stored_alarm_hours;
        sa_m       = req.stored_alarm_minutes;
        cmd        = csm_pkg::CMD_NONE;
        en         = req.alarm_on;
        last_press = cur.last_press;
        up         = (req.op == csm_pkg::OP_INC);
        edit_time  = 1'b0;
        eh         = 5'd0;
        em         = 6'd0;
        prod       = 10'd0;
        tens       = 3'd0;
        unit_diff  = 6'd0;
        units      = 4'd0;

        if (req.ringing)
            mode = csm_pkg::MODE_RINGING;
        else if (mode == csm_pkg::MODE_RINGING)
            mode = csm_pkg::MODE_HOME;

        if (!req.ringing && req.op != csm_pkg::OP_NONE && req.press_seen)
        begin
            case (req.op)
                csm_pkg::OP_MODE:
                begin
                    if (mode == csm_pkg::MODE_HOME || step == csm_pkg::STEP_SELECT)
                    begin
                        case (mode)
                            csm_pkg::MODE_HOME:    mode = csm_pkg::MODE_ENABLE;
                            csm_pkg::MODE_ENABLE:  mode = csm_pkg::MODE_SET_ALM;
                            csm_pkg::MODE_SET_ALM: mode = csm_pkg::MODE_SET_TIME;
                            default:               mode = csm_pkg::MODE_HOME;
                        endcase
                        step = csm_pkg::STEP_SELECT;
                    end
                end
                csm_pkg::OP_SET:
                begin
                    if (mode == csm_pkg::MODE_ENABLE)
                    begin
                        en   = !req.alarm_on;
                        cmd  = csm_pkg::CMD_ENABLE;
                        mode = csm_pkg::MODE_HOME;
                    end
                    else if (mode == csm_pkg::MODE_SET_ALM || mode == csm_pkg::MODE_SET_TIME)
                    begin
                        if (step != csm_pkg::STEP_UNITS)
                            step = step + 2'd1;
                        else
                        begin
                            if (mode == csm_pkg::MODE_SET_TIME)
                            begin
                                cmd   = csm_pkg::CMD_CLOCK;
                                clk_h = dh;
                                clk_m = dm;
                            end
                            else
                            begin
                                cmd  = csm_pkg::CMD_ALARM;
                                sa_h = ah;
                                sa_m = am;
                            end
                            mode = csm_pkg::MODE_HOME;
                        end
                    end
                end
                csm_pkg::OP_INC, csm_pkg::OP_DEC:
                begin
                    if (mode == csm_pkg::MODE_SET_ALM || mode == csm_pkg::MODE_SET_TIME)
                    begin
                        edit_time = (mode == csm_pkg::MODE_SET_TIME);
                        eh        = edit_time ? dh : ah;
                        em        = edit_time ? dm : am;
                        prod      = {4'b0000, em} * 10'd13;
                        tens      = prod[9:7];
                        unit_diff = em - times_ten(tens);
                        units     = unit_diff[3:0];
                        case (step)
                            csm_pkg::STEP_HOURS: eh = wrap_hours(up, eh);
                            csm_pkg::STEP_TENS:  em = times_ten(wrap_tens(up, tens))
                                                      + {2'b00, units};
                            csm_pkg::STEP_UNITS: em = times_ten(tens)
                                                      + {2'b00, wrap_units(up, units)};
                            default: ;
                        endcase
                        if (edit_time)
                        begin
                            dh = eh;
                            dm = em;
                        end
                        else
                        begin
                            ah = eh;
                            am = em;
                        end
                    end
                end
                default: ;
            endcase
        end

        elapsed = req.now_ms - cur.last_press;
        if (mode == csm_pkg::MODE_HOME)
        begin
            dh = clk_h;
            dm = clk_m;
            ah = sa_h;
            am = sa_m;
        end
        else if (req.press_seen)
            last_press = req.now_ms;
        else if (elapsed > idle_timeout)
            mode = csm_pkg::MODE_HOME;
    end

    assign dh_r = (dh >= 5'd24) ? dh - 5'd24 : dh;
    assign dm_r = (dm >= 6'd60) ? dm - 6'd60 : dm;
    assign ah_r = (ah >= 5'd24) ? ah - 5'd24 : ah;
    assign am_r = (am >= 6'd60) ? am - 6'd60 : am;

    always_comb
    begin
        c_on  = 1'b0;
        c_row = 1'b0;
        c_col = csm_pkg::COL_NONE;
        if ((mode == csm_pkg::MODE_SET_TIME || mode == csm_pkg::MODE_SET_ALM)
            && step != csm_pkg::STEP_SELECT)
        begin
            c_on  = 1'b1;
            c_row = (mode == csm_pkg::MODE_SET_ALM);
            case (step)
                csm_pkg::STEP_HOURS: c_col = csm_pkg::COL_HOURS;
                csm_pkg::STEP_TENS:  c_col = csm_pkg::COL_TENS;
                default:             c_col = csm_pkg::COL_UNITS;
            endcase
        end
        else if (mode == csm_pkg::MODE_ENABLE)
        begin
            c_on  = 1'b1;
            c_row = 1'b1;
            c_col = csm_pkg::COL_ENABLE;
        end
    end

    always_comb
    begin
        nxt.mode        = mode;
        nxt.step        = step;
        nxt.day_hours   = dh_r;
        nxt.day_minutes = dm_r;
        nxt.alm_hours   = ah_r;
        nxt.alm_minutes = am_r;
        nxt.last_press  = last_press;

        res.mode_now            = mode;
        res.step_now            = step;
        res.shown_hours         = dh_r;
        res.shown_minutes       = dm_r;
        res.shown_alarm_hours   = ah_r;
        res.shown_alarm_minutes = am_r;
        res.command             = cmd;
        res.enable_value        = en;
        res.changed             = (mode != cur.mode) || (step != cur.step)
                                  || (dh_r != cur.day_hours) || (dm_r != cur.day_minutes)
                                  || (ah_r != cur.alm_hours) || (am_r != cur.alm_minutes);
        res.cursor_on           = c_on;
        res.cursor_row          = c_row;
        res.cursor_col          = c_col;
    end

endmodule
`default_nettype wire

// ----- rtl/clock_set_mode_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Clock set mode controller
// Alarm-clock mode, edit step and time editing with idle fallback to home.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one poll request (button, flags, timer,
//   current clock and stored alarm). out_valid/out_ready/out_data return one
//   result per request, in order.
//   cfg_we/cfg_wdata write the idle timeout; write it only while idle.
// Path: a request accepted into the input register has its result on the
//   outputs from the result register.
// Throughput: one request per cycle while out_ready is high; the state update is a
//   single pass of logic between the input register and the result register.
// Stall: while a result waits on out_ready, one more request is taken into
//   the input register; in_ready drops only when both registers are full.
// Reset: rst_n clears mode to home, step to select, kept times and the last
//   press time to zero, and loads the idle timeout with 0x7500. Both
//   registers come out of reset empty.
// ----------------------------------------------------------------------------
module clock_set_mode_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  var csm_pkg::csm_in_t   in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output csm_pkg::csm_out_t      out_data,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata
);

    logic                in_valid_reg;
    csm_pkg::csm_in_t    in_data_reg;
    logic                out_valid_reg;
    csm_pkg::csm_out_t   out_data_reg;
    csm_pkg::csm_state_t state_reg;
    csm_pkg::csm_state_t state_next;
    csm_pkg::csm_out_t   result_next;
    logic [15:0]         timeout_reg;
    logic                advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    csm_next u_next (
        .cur          (state_reg),
        .req          (in_data_reg),
        .idle_timeout (timeout_reg),
        .nxt          (state_next),
        .res          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= csm_pkg::IDLE_TIMEOUT_RESET;
        else if (cfg_we)
            timeout_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result_next;
    end

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled after advance");

    a_ringing_mode: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.ringing && in_data_reg.press_seen
        |=> out_data_reg.mode_now == csm_pkg::MODE_RINGING)
        else $error("ringing request did not give ringing mode");

    a_cmd_home: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.command != csm_pkg::CMD_NONE
        |-> out_data_reg.mode_now == csm_pkg::MODE_HOME)
        else $error("command issued outside home mode");

    a_cursor_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.cursor_on
        |-> out_data_reg.mode_now == csm_pkg::MODE_ENABLE
            || out_data_reg.mode_now == csm_pkg::MODE_SET_ALM
            || out_data_reg.mode_now == csm_pkg::MODE_SET_TIME)
        else $error("cursor shown in a mode without editing");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock set mode controller testbench
// Sends poll requests through the valid/ready input and predicts each result
// with an in-bench model of the mode, edit step, kept times and idle timeout.
// Directed tests cover field extremes, alarm enable, alarm and clock edits
// with wrap, ringing and timeout boundaries; random sessions then run under
// several idle and stall mixes and idle timeout settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int OP_SPARE_LO = 5;
    localparam int OP_SPARE_HI = 7;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    csm_pkg::csm_in_t  in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    csm_pkg::csm_out_t out_data;
    logic              cfg_we = 1'b0;
    logic [15:0]       cfg_wdata = '0;

    csm_pkg::mode_t    kept_mode = csm_pkg::MODE_HOME;
    logic [1:0]        kept_step = csm_pkg::STEP_SELECT;
    int                kept_day_h = 0;
    int                kept_day_m = 0;
    int                kept_alm_h = 0;
    int                kept_alm_m = 0;
    logic [15:0]       last_press = '0;
    logic [15:0]       idle_to = csm_pkg::IDLE_TIMEOUT_RESET;

    csm_pkg::csm_out_t status_due[$];
    csm_pkg::csm_out_t want;
    logic [15:0]       tick_ms = '0;
    bit                jumps_on = 1'b0;
    int                gap_pct = 0;
    int                stall_pct = 0;
    int                hold_req = 0;
    int                stall_left = 0;
    int                sent_count = 0;
    int                mismatches = 0;

    clock_set_mode_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int step_wrap(input bit up, input int v, input int modulus);
        if (up)
            return (v + 1) % modulus;
        return (v >= 1) ? v - 1 : modulus - 1;
    endfunction

    function automatic csm_pkg::csm_out_t next_status(input csm_pkg::csm_in_t r);
        csm_pkg::mode_t    m;
        logic [1:0]        s;
        logic [1:0]        cmd;
        logic              en;
        logic              up;
        logic              chg;
        logic [15:0]       elapsed;
        int                dh, dm, ah, am, tens, units;
        csm_pkg::csm_out_t o;

        m = kept_mode;
        s = kept_step;
        dh = kept_day_h;
        dm = kept_day_m;
        ah = kept_alm_h;
        am = kept_alm_m;
        cmd = csm_pkg::CMD_NONE;
        en = r.alarm_on;
        elapsed = r.now_ms - last_press;

        if (r.ringing)
            m = csm_pkg::MODE_RINGING;
        else if (m == csm_pkg::MODE_RINGING)
            m = csm_pkg::MODE_HOME;

        if (!r.ringing && r.press_seen && r.op != csm_pkg::OP_NONE)
        begin
            if (r.op == csm_pkg::OP_MODE)
            begin
                if (m == csm_pkg::MODE_HOME || s == csm_pkg::STEP_SELECT)
                begin
                    case (m)
                        csm_pkg::MODE_HOME:    m = csm_pkg::MODE_ENABLE;
                        csm_pkg::MODE_ENABLE:  m = csm_pkg::MODE_SET_ALM;
                        csm_pkg::MODE_SET_ALM: m = csm_pkg::MODE_SET_TIME;
                        default:               m = csm_pkg::MODE_HOME;
                    endcase
                    s = csm_pkg::STEP_SELECT;
                end
            end
            else if (r.op == csm_pkg::OP_SET)
            begin
                if (m == csm_pkg::MODE_ENABLE)
                begin
                    en = !r.alarm_on;
                    cmd = csm_pkg::CMD_ENABLE;
                    m = csm_pkg::MODE_HOME;
                end
                else if (m == csm_pkg::MODE_SET_ALM || m == csm_pkg::MODE_SET_TIME)
                begin
                    if (s != csm_pkg::STEP_UNITS)
                        s = s + 2'd1;
                    else
                    begin
                        cmd = (m == csm_pkg::MODE_SET_TIME) ? csm_pkg::CMD_CLOCK
                                                            : csm_pkg::CMD_ALARM;
                        m = csm_pkg::MODE_HOME;
                    end
                end
            end
            else if ((r.op == csm_pkg::OP_INC || r.op == csm_pkg::OP_DEC) &&
                     (m == csm_pkg::MODE_SET_ALM || m == csm_pkg::MODE_SET_TIME))
            begin
                up = (r.op == csm_pkg::OP_INC);
                if (s == csm_pkg::STEP_HOURS)
                begin
                    if (m == csm_pkg::MODE_SET_TIME)
                        dh = step_wrap(up, dh, 24);
                    else
                        ah = step_wrap(up, ah, 24);
                end
                else if (s != csm_pkg::STEP_SELECT)
                begin
                    tens = ((m == csm_pkg::MODE_SET_TIME) ? dm : am) / 10;
                    units = ((m == csm_pkg::MODE_SET_TIME) ? dm : am) % 10;
                    if (s == csm_pkg::STEP_TENS)
                        tens = step_wrap(up, tens, 6);
                    else
                        units = step_wrap(up, units, 10);
                    if (m == csm_pkg::MODE_SET_TIME)
                        dm = tens * 10 + units;
                    else
                        am = tens * 10 + units;
                end
            end
        end

        if (m == csm_pkg::MODE_HOME)
        begin
            if (cmd != csm_pkg::CMD_CLOCK)
            begin
                dh = int'(r.clock_hours);
                dm = int'(r.clock_minutes);
            end
            if (cmd != csm_pkg::CMD_ALARM)
            begin
                ah = int'(r.stored_alarm_hours);
                am = int'(r.stored_alarm_minutes);
            end
        end
        else if (r.press_seen)
            last_press = r.now_ms;
        else if (elapsed > idle_to)
            m = csm_pkg::MODE_HOME;

        dh = dh % 24;
        dm = dm % 60;
        ah = ah % 24;
        am = am % 60;

        chg = m != kept_mode || s != kept_step || dh != kept_day_h ||
              dm != kept_day_m || ah != kept_alm_h || am != kept_alm_m;

        kept_mode = m;
        kept_step = s;
        kept_day_h = dh;
        kept_day_m = dm;
        kept_alm_h = ah;
        kept_alm_m = am;

        o = '0;
        o.mode_now = m;
        o.step_now = s;
        o.shown_hours = 5'(dh);
        o.shown_minutes = 6'(dm);
        o.shown_alarm_hours = 5'(ah);
        o.shown_alarm_minutes = 6'(am);
        o.command = cmd;
        o.enable_value = en;
        o.changed = chg;
        o.cursor_col = csm_pkg::COL_NONE;
        if ((m == csm_pkg::MODE_SET_TIME || m == csm_pkg::MODE_SET_ALM) &&
            s != csm_pkg::STEP_SELECT)
        begin
            o.cursor_on = 1'b1;
            o.cursor_row = (m == csm_pkg::MODE_SET_ALM);
            o.cursor_col = (s == csm_pkg::STEP_HOURS) ? csm_pkg::COL_HOURS :
                           (s == csm_pkg::STEP_TENS) ? csm_pkg::COL_TENS : csm_pkg::COL_UNITS;
        end
        else if (m == csm_pkg::MODE_ENABLE)
        begin
            o.cursor_on = 1'b1;
            o.cursor_row = 1'b1;
            o.cursor_col = csm_pkg::COL_ENABLE;
        end
        return o;
    endfunction

    function automatic csm_pkg::csm_in_t make_poll(input logic [2:0] op, input logic press,
                                                   input logic ring);
        csm_pkg::csm_in_t q;

        if (jumps_on && $urandom_range(39) == 0)
            tick_ms = tick_ms + 16'($urandom);
        else
            tick_ms = tick_ms + 16'($urandom_range(1, 30));
        q.op = op;
        q.press_seen = press;
        q.ringing = ring;
        q.alarm_on = 1'($urandom_range(1));
        q.now_ms = tick_ms;
        q.clock_hours = ($urandom_range(15) == 0) ?
                        5'($urandom_range(31)) : 5'($urandom_range(23));
        q.clock_minutes = ($urandom_range(15) == 0) ?
                          6'($urandom_range(63)) : 6'($urandom_range(59));
        q.stored_alarm_hours = ($urandom_range(15) == 0) ?
                               5'($urandom_range(31)) : 5'($urandom_range(23));
        q.stored_alarm_minutes = ($urandom_range(15) == 0) ?
                                 6'($urandom_range(63)) : 6'($urandom_range(59));
        return q;
    endfunction

    function automatic csm_pkg::csm_in_t noise_poll();
        return make_poll(3'($urandom_range(7)), 1'($urandom_range(1)), $urandom_range(7) == 0);
    endfunction

    task automatic send_request(input csm_pkg::csm_in_t r);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        status_due.push_back(next_status(r));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic press_key(input logic [2:0] op);
        send_request(make_poll(op, 1'b1, 1'b0));
    endtask

    task automatic poll_at(input logic [2:0] op, input logic press, input logic ring,
                           input logic [15:0] stamp);
        csm_pkg::csm_in_t q;

        q = make_poll(op, press, ring);
        q.now_ms = stamp;
        tick_ms = stamp;
        send_request(q);
    endtask

    task automatic wait_drain();
        int guard;

        guard = 0;
        in_valid <= 1'b0;
        while (status_due.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        idle_to = v;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            stall_left = hold_req;
            hold_req = 0;
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status_due.size() == 0)
            begin
                $error("result with no request pending");
                mismatches++;
            end
            else
            begin
                want = status_due.pop_front();
                check_field("mode_now", 16'(want.mode_now), 16'(out_data.mode_now));
                check_field("step_now", 16'(want.step_now), 16'(out_data.step_now));
                check_field("shown_hours", 16'(want.shown_hours),
                            16'(out_data.shown_hours));
                check_field("shown_minutes", 16'(want.shown_minutes),
                            16'(out_data.shown_minutes));
                check_field("shown_alarm_hours", 16'(want.shown_alarm_hours),
                            16'(out_data.shown_alarm_hours));
                check_field("shown_alarm_minutes", 16'(want.shown_alarm_minutes),
                            16'(out_data.shown_alarm_minutes));
                check_field("command", 16'(want.command), 16'(out_data.command));
                check_field("enable_value", 16'(want.enable_value),
                            16'(out_data.enable_value));
                check_field("changed", 16'(want.changed), 16'(out_data.changed));
                check_field("cursor_on", 16'(want.cursor_on), 16'(out_data.cursor_on));
                check_field("cursor_row", 16'(want.cursor_row), 16'(out_data.cursor_row));
                check_field("cursor_col", 16'(want.cursor_col), 16'(out_data.cursor_col));
            end
        end
    end

    task automatic go_home();
        int i;

        for (i = 0; i < 8 && kept_mode != csm_pkg::MODE_HOME; i++)
        begin
            if (kept_mode == csm_pkg::MODE_RINGING)
                send_request(make_poll(csm_pkg::OP_NONE, 1'b0, 1'b0));
            else
                press_key((kept_step == csm_pkg::STEP_SELECT) ? csm_pkg::OP_MODE
                                                               : csm_pkg::OP_SET);
        end
    endtask

    task automatic edit_session(input csm_pkg::mode_t target);
        int rounds, i, j;

        go_home();
        press_key(csm_pkg::OP_MODE);
        press_key(csm_pkg::OP_MODE);
        if (target == csm_pkg::MODE_SET_TIME)
            press_key(csm_pkg::OP_MODE);
        rounds = $urandom_range(1, 4);
        for (i = 0; i < rounds; i++)
        begin
            press_key(csm_pkg::OP_SET);
            for (j = $urandom_range(0, 6); j > 0; j--)
            begin
                case ($urandom_range(9))
                    0:       send_request(make_poll(csm_pkg::OP_NONE, 1'b0, 1'b0));
                    1:       send_request(noise_poll());
                    2:       press_key(csm_pkg::OP_MODE);
                    3, 4, 5: press_key(csm_pkg::OP_INC);
                    default: press_key(csm_pkg::OP_DEC);
                endcase
            end
        end
    endtask

    task automatic random_session();
        int n;

        case ($urandom_range(15))
            0, 1: repeat ($urandom_range(1, 6)) send_request(noise_poll());
            2:
            begin
                for (n = $urandom_range(1, 4); n > 0; n--)
                    send_request(make_poll(3'($urandom_range(4)), 1'($urandom_range(1)), 1'b1));
                send_request(make_poll(csm_pkg::OP_NONE, 1'b0, 1'b0));
            end
            3: wait_drain();
            4, 5:
            begin
                go_home();
                press_key(csm_pkg::OP_MODE);
                repeat ($urandom_range(0, 2))
                    send_request(make_poll(csm_pkg::OP_NONE, 1'b0, 1'b0));
                if ($urandom_range(3) != 0)
                    press_key(csm_pkg::OP_SET);
            end
            6, 7, 8, 9, 10: edit_session(csm_pkg::MODE_SET_ALM);
            default: edit_session(csm_pkg::MODE_SET_TIME);
        endcase
    endtask

    task automatic test_field_extremes();
        csm_pkg::csm_in_t q;

        q = '0;
        send_request(q);
        q = '1;
        q.op = csm_pkg::OP_NONE;
        q.ringing = 1'b0;
        send_request(q);
    endtask

    task automatic test_alarm_enable();
        csm_pkg::csm_in_t q;
        int               i;

        for (i = 0; i < 2; i++)
        begin
            press_key(csm_pkg::OP_MODE);
            q = make_poll(csm_pkg::OP_SET, 1'b1, 1'b0);
            q.alarm_on = i[0];
            send_request(q);
        end
    endtask

    task automatic test_alarm_edit();
        csm_pkg::csm_in_t q;
        int               k;

        q = make_poll(csm_pkg::OP_NONE, 1'b0, 1'b0);
        q.stored_alarm_hours = 5'd23;
        q.stored_alarm_minutes = 6'd59;
        send_request(q);
        press_key(csm_pkg::OP_MODE);
        press_key(csm_pkg::OP_MODE);
        press_key(csm_pkg::OP_INC);
        press_key(csm_pkg::OP_SET);
        press_key(csm_pkg::OP_INC);
        press_key(csm_pkg::OP_MODE);
        press_key(csm_pkg::OP_SET);
        press_key(csm_pkg::OP_INC);
        press_key(csm_pkg::OP_SET);
        press_key(csm_pkg::OP_INC);
        for (k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
            press_key(3'(k));
        send_request(make_poll(csm_pkg::OP_SET, 1'b0, 1'b0));
        press_key(csm_pkg::OP_SET);
    endtask

    task automatic test_time_edit();
        csm_pkg::csm_in_t q;

        q = make_poll(csm_pkg::OP_NONE, 1'b0, 1'b0);
        q.clock_hours = 5'd0;
        q.clock_minutes = 6'd0;
        send_request(q);
        repeat (3) press_key(csm_pkg::OP_MODE);
        repeat (3)
        begin
            press_key(csm_pkg::OP_SET);
            press_key(csm_pkg::OP_DEC);
        end
        press_key(csm_pkg::OP_SET);
        send_request(make_poll(csm_pkg::OP_NONE, 1'b0, 1'b0));
        repeat (4) press_key(csm_pkg::OP_MODE);
    endtask

    task automatic test_ringing();
        press_key(csm_pkg::OP_MODE);
        poll_at(csm_pkg::OP_SET, 1'b1, 1'b1, tick_ms + 16'd1);
        poll_at(csm_pkg::OP_NONE, 1'b0, 1'b1, tick_ms + 16'h8000);
        poll_at(csm_pkg::OP_INC, 1'b1, 1'b1, tick_ms + 16'd1);
        poll_at(csm_pkg::OP_MODE, 1'b0, 1'b0, tick_ms + 16'd1);
    endtask

    task automatic test_idle_timeout();
        write_timeout(16'd10);
        poll_at(csm_pkg::OP_MODE, 1'b1, 1'b0, 16'hFFFA);
        poll_at(csm_pkg::OP_NONE, 1'b0, 1'b0, 16'h0004);
        poll_at(csm_pkg::OP_NONE, 1'b0, 1'b0, 16'h0005);
        write_timeout(16'd0);
        poll_at(csm_pkg::OP_MODE, 1'b1, 1'b0, 16'h1234);
        poll_at(csm_pkg::OP_NONE, 1'b0, 1'b0, 16'h1234);
        poll_at(csm_pkg::OP_NONE, 1'b0, 1'b0, 16'h1235);
        write_timeout(16'hFFFF);
        poll_at(csm_pkg::OP_MODE, 1'b1, 1'b0, 16'h0000);
        poll_at(csm_pkg::OP_NONE, 1'b0, 1'b0, 16'hFFFF);
        repeat (3) press_key(csm_pkg::OP_MODE);
    endtask

    task automatic test_backpressure();
        wait_drain();
        gap_pct = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_req = 80;
        @(negedge clk);
        repeat (24) send_request(noise_poll());
        wait_drain();
        repeat (8) send_request(noise_poll());
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n, input int gp, input int sp,
                                       input logic [15:0] limit_ms);
        int goal;

        write_timeout(limit_ms);
        gap_pct = gp;
        stall_pct = sp;
        jumps_on = 1'b1;
        goal = sent_count + n;
        while (sent_count < goal)
            random_session();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_field_extremes();
        test_alarm_enable();
        test_alarm_edit();
        test_time_edit();
        test_ringing();
        test_idle_timeout();
        test_backpressure();
        test_random_traffic(170, 0, 0, csm_pkg::IDLE_TIMEOUT_RESET);
        test_random_traffic(170, 67, 0, 16'd300);
        test_random_traffic(170, 0, 67, 16'hFFFF);
        test_random_traffic(170, 31, 31, 16'($urandom_range(20, 2000)));
        wait_drain();
        if (status_due.size() != 0)
        begin
            $error("%0d results never arrived", status_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- clock_set_mode_controller.f -----
rtl/csm_pkg.sv
rtl/csm_next.sv
rtl/clock_set_mode_controller.sv
test/tb.sv
